// ===== rtl/core/gra_pkg.sv =====
package gra_pkg;

  localparam int MAX_NODES = 256;
  localparam int MAX_FREE  = 128;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int NCNT_W    = $clog2(MAX_NODES + 1);
  localparam int FREE_AW   = $clog2(MAX_FREE);
  localparam int FCNT_W    = $clog2(MAX_FREE + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H = 1'b1;
  localparam logic [15:0]          ATLAS_RST   = 16'd1024;

  typedef logic [15:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef logic [1:0] res_kind_t;
  localparam res_kind_t RES_FAIL = 2'd0;
  localparam res_kind_t RES_GET  = 2'd1;
  localparam res_kind_t RES_INS  = 2'd2;

  typedef logic [1:0] nsel_t;
  localparam nsel_t NSEL_A = 2'd0;
  localparam nsel_t NSEL_B = 2'd1;
  localparam nsel_t NSEL_C = 2'd2;

  typedef struct packed {
    logic      latch_req;
    logic      idx_clr;
    logic      idx_fc;
    logic      idx_inc;
    logic      idx_dec;
    logic      f_rd;
    logic      f_rd_prev;
    logic      f_wr_elem;
    logic      f_wr_move;
    logic      sel_c;
    logic      src_load;
    logic      n_rd;
    logic      n_wr;
    nsel_t     nsel;
    logic      load_res;
    res_kind_t kind;
    logic      commit;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic fit;
    logic scan_last;
    logic idx_zero;
    logic move;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/core/gra_if.sv =====
interface gra_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] req_width;
  logic [15:0] req_height;
  logic [7:0]  node_key;

  modport source(output valid, func, req_width, req_height, node_key, input ready);
  modport sink(input valid, func, req_width, req_height, node_key, output ready);
endinterface

interface gra_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [7:0]  node_index;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [15:0] rect_w;
  logic [15:0] rect_h;

  modport source(output valid, ok, node_index, rect_x, rect_y, rect_w, rect_h,
                 input ready);
  modport sink(input valid, ok, node_index, rect_x, rect_y, rect_w, rect_h,
               output ready);
endinterface

// ===== rtl/core/gra_dp.sv =====
module gra_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gra_pkg::CFG_DW-1:0]     cfg_wdata,
  input  logic                           in_func,
  input  logic [15:0]                    in_req_width,
  input  logic [15:0]                    in_req_height,
  input  logic [7:0]                     in_node_key,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [7:0]                     out_node_index,
  output logic [15:0]                    out_rect_x,
  output logic [15:0]                    out_rect_y,
  output logic [15:0]                    out_rect_w,
  output logic [15:0]                    out_rect_h,
  input  gra_pkg::cmd_t                  cmd,
  output gra_pkg::sts_t                  sts
);
  import gra_pkg::*;

  coord_t            atlas_w_r, atlas_h_r;
  logic [NCNT_W-1:0] nc_r;
  logic [FCNT_W-1:0] fc_r;
  logic              e0v_r;
  logic [FCNT_W-1:0] idx_r;
  logic              func_r;
  coord_t            rw_r, rh_r;
  logic [7:0]        key_r;
  rect_t             src_r;

  rect_t             fmem [MAX_FREE];
  rect_t             frd_r;
  logic              f0a_r;
  rect_t             nmem [MAX_NODES];
  rect_t             nrd_r;

  logic              out_valid_r;
  logic              ok_r;
  logic [7:0]        nidx_r;
  rect_t             res_r;

  rect_t             atlas, fdat, ra, rb, rc, elem, nwdata, get_rect;
  logic [16:0]       kelem, kdat;
  logic [FREE_AW-1:0] fraddr;
  logic [FREE_AW-1:0] fwaddr;
  logic              fwe;
  rect_t             fwdata;
  logic [NODE_AW-1:0] nwaddr;
  logic [NCNT_W-1:0] noff;
  logic              get_ok;

  assign atlas  = '{x: 16'd0, y: 16'd0, w: atlas_w_r, h: atlas_h_r};
  assign fdat   = f0a_r ? atlas : frd_r;
  assign ra     = '{x: src_r.x, y: src_r.y, w: rw_r, h: rh_r};
  assign rb     = '{x: src_r.x + rw_r, y: src_r.y, w: src_r.w - rw_r, h: rh_r};
  assign rc     = '{x: src_r.x, y: src_r.y + rh_r, w: src_r.w, h: src_r.h - rh_r};
  assign elem   = cmd.sel_c ? rc : rb;
  assign kelem  = {1'b0, elem.w} + {1'b0, elem.h};
  assign kdat   = {1'b0, fdat.w} + {1'b0, fdat.h};
  assign fraddr = cmd.f_rd_prev ? FREE_AW'(idx_r - 1'b1) : idx_r[FREE_AW-1:0];
  assign fwaddr = idx_r[FREE_AW-1:0];
  assign fwe    = cmd.f_wr_elem | cmd.f_wr_move;
  assign fwdata = cmd.f_wr_move ? fdat : elem;

  always_comb begin
    case (cmd.nsel)
      NSEL_A:  begin noff = NCNT_W'(0); nwdata = ra; end
      NSEL_B:  begin noff = NCNT_W'(1); nwdata = rb; end
      NSEL_C:  begin noff = NCNT_W'(2); nwdata = rc; end
      default: begin noff = NCNT_W'(0); nwdata = ra; end
    endcase
  end
  assign nwaddr = NODE_AW'(nc_r + noff);

  assign get_ok   = {1'b0, key_r} < nc_r;
  assign get_rect = !get_ok ? '0 : ((key_r == 8'd0) ? atlas : nrd_r);

  assign sts.func      = func_r;
  assign sts.full      = ({1'b0, nc_r} + (NCNT_W+1)'(3) > (NCNT_W+1)'(MAX_NODES)) ||
                         ({1'b0, fc_r} + (FCNT_W+1)'(1) > (FCNT_W+1)'(MAX_FREE));
  assign sts.fit       = (fdat.w >= rw_r) && (fdat.h >= rh_r);
  assign sts.scan_last = idx_r == fc_r - 1'b1;
  assign sts.idx_zero  = idx_r == '0;
  assign sts.move      = kdat > kelem;
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= ATLAS_RST;
      atlas_h_r <= ATLAS_RST;
      nc_r      <= NCNT_W'(1);
      fc_r      <= FCNT_W'(1);
      e0v_r     <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ATLAS_W) begin
        atlas_w_r <= cfg_wdata;
      end else begin
        atlas_h_r <= cfg_wdata;
      end
      nc_r  <= NCNT_W'(1);
      fc_r  <= FCNT_W'(1);
      e0v_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        nc_r <= nc_r + NCNT_W'(3);
        fc_r <= fc_r + FCNT_W'(1);
      end
      if (fwe && fwaddr == '0) begin
        e0v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      func_r <= in_func;
      rw_r   <= in_req_width;
      rh_r   <= in_req_height;
      key_r  <= in_node_key;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_fc) begin
      idx_r <= fc_r;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.src_load) begin
      src_r <= fdat;
    end
    if (cmd.f_rd || cmd.f_rd_prev) begin
      frd_r <= fmem[fraddr];
      f0a_r <= (fraddr == '0) && !e0v_r;
    end
    if (fwe) begin
      fmem[fwaddr] <= fwdata;
    end
    if (cmd.n_rd) begin
      nrd_r <= nmem[key_r[NODE_AW-1:0]];
    end
    if (cmd.n_wr) begin
      nmem[nwaddr] <= nwdata;
    end
    if (cmd.load_res) begin
      case (cmd.kind)
        RES_GET: begin
          ok_r   <= get_ok;
          nidx_r <= key_r;
          res_r  <= get_rect;
        end
        RES_INS: begin
          ok_r   <= 1'b1;
          nidx_r <= nc_r[7:0];
          res_r  <= ra;
        end
        default: begin
          ok_r   <= 1'b0;
          nidx_r <= 8'd0;
          res_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_node_index = nidx_r;
  assign out_rect_x     = res_r.x;
  assign out_rect_y     = res_r.y;
  assign out_rect_w     = res_r.w;
  assign out_rect_h     = res_r.h;

endmodule

// ===== rtl/core/gra_ctrl.sv =====
module gra_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gra_pkg::sts_t sts,
  output gra_pkg::cmd_t cmd
);
  import gra_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_NODE_A   = 4'd4;
  localparam logic [3:0] S_NODE_B   = 4'd5;
  localparam logic [3:0] S_NODE_C   = 4'd6;
  localparam logic [3:0] S_SINK_RD  = 4'd7;
  localparam logic [3:0] S_SINK_CHK = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       phase_c_r, phase_c_nxt;
  res_kind_t  kind_r, kind_nxt;
  logic       sink_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_c_r <= 1'b0;
      kind_r    <= RES_FAIL;
    end else begin
      state_r   <= state_nxt;
      phase_c_r <= phase_c_nxt;
      kind_r    <= kind_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    phase_c_nxt = phase_c_r;
    kind_nxt    = kind_r;
    sink_end    = 1'b0;
    cmd.sel_c   = phase_c_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.func) begin
          cmd.n_rd  = 1'b1;
          kind_nxt  = RES_GET;
          state_nxt = S_DONE;
        end else if (sts.full) begin
          kind_nxt  = RES_FAIL;
          state_nxt = S_DONE;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.f_rd  = 1'b1;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.fit) begin
          cmd.src_load = 1'b1;
          state_nxt    = S_NODE_A;
        end else if (sts.scan_last) begin
          kind_nxt  = RES_FAIL;
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_NODE_A: begin
        cmd.n_wr  = 1'b1;
        cmd.nsel  = NSEL_A;
        state_nxt = S_NODE_B;
      end
      S_NODE_B: begin
        cmd.n_wr  = 1'b1;
        cmd.nsel  = NSEL_B;
        state_nxt = S_NODE_C;
      end
      S_NODE_C: begin
        cmd.n_wr    = 1'b1;
        cmd.nsel    = NSEL_C;
        phase_c_nxt = 1'b0;
        state_nxt   = S_SINK_RD;
      end
      S_SINK_RD: begin
        if (sts.idx_zero) begin
          cmd.f_wr_elem = 1'b1;
          sink_end      = 1'b1;
        end else begin
          cmd.f_rd_prev = 1'b1;
          state_nxt     = S_SINK_CHK;
        end
      end
      S_SINK_CHK: begin
        if (sts.move) begin
          cmd.f_wr_move = 1'b1;
          cmd.idx_dec   = 1'b1;
          state_nxt     = S_SINK_RD;
        end else begin
          cmd.f_wr_elem = 1'b1;
          sink_end      = 1'b1;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_res = 1'b1;
          cmd.kind     = kind_r;
          cmd.commit   = kind_r == RES_INS;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (sink_end) begin
      if (!phase_c_r) begin
        phase_c_nxt = 1'b1;
        cmd.idx_fc  = 1'b1;
        state_nxt   = S_SINK_RD;
      end else begin
        kind_nxt  = RES_INS;
        state_nxt = S_DONE;
      end
    end
  end

endmodule

// ===== rtl/core/guillotine_rect_allocator.sv =====
// Guillotine rectangle allocator, first fit over a free list kept sorted by
// width plus height. A get reads its node and then loads the result. An
// insert checks for room, scans the free entries up to and including the
// first fit, writes the three new nodes, then for each of the two remainders
// shifts each larger free entry up one place before placing it, then loads
// the result. A new item is accepted only once the previous one has reached
// the output register, which waits while the output is stalled. Writing either
// atlas register restarts the allocator with the whole atlas as node 0 and the
// only free rectangle.
module guillotine_rect_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  gra_in_if.sink                        in_ch,
  gra_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gra_pkg::CFG_DW-1:0]    cfg_wdata
);
  import gra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gra_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_func        (in_ch.func),
    .in_req_width   (in_ch.req_width),
    .in_req_height  (in_ch.req_height),
    .in_node_key    (in_ch.node_key),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ok         (out_ch.ok),
    .out_node_index (out_ch.node_index),
    .out_rect_x     (out_ch.rect_x),
    .out_rect_y     (out_ch.rect_y),
    .out_rect_w     (out_ch.rect_w),
    .out_rect_h     (out_ch.rect_h),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== rtl/core/gra_checker.sv =====
module gra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic [7:0]  out_node_index,
  input logic [15:0] out_rect_x,
  input logic [15:0] out_rect_y,
  input logic [15:0] out_rect_w,
  input logic [15:0] out_rect_h
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_ok) && $stable(out_node_index) &&
      $stable(out_rect_x) && $stable(out_rect_y) && $stable(out_rect_w) &&
      $stable(out_rect_h))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_rect_x == 16'd0 && out_rect_y == 16'd0 &&
      out_rect_w == 16'd0 && out_rect_h == 16'd0)
    else $error("failed result carries a rectangle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown out of reset");

endmodule

bind guillotine_rect_allocator gra_checker u_gra_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_ok         (out_ch.ok),
  .out_node_index (out_ch.node_index),
  .out_rect_x     (out_ch.rect_x),
  .out_rect_y     (out_ch.rect_y),
  .out_rect_w     (out_ch.rect_w),
  .out_rect_h     (out_ch.rect_h)
);

// ===== dv/guillotine_rect_allocator_tb.sv =====
`timescale 1ns / 100ps

module guillotine_rect_allocator_tb;
  import gra_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [7:0] idx;
    rect_t      rect;
  } alloc_res_t;

  class atlas_scoreboard;
    rect_t      nodes[MAX_NODES];
    int         node_cnt;
    rect_t      free_list[MAX_FREE];
    int         free_node[MAX_FREE];
    int         free_cnt;
    logic [15:0] atlas_w;
    logic [15:0] atlas_h;
    alloc_res_t  awaited[$];
    int          errors;
    int          n_ins_ok;
    int          n_ins_fail;
    int          n_get;
    int          n_checked;

    function new();
      atlas_w = ATLAS_RST;
      atlas_h = ATLAS_RST;
      errors = 0;
      clear_store();
    endfunction

    function void clear_store();
      foreach (nodes[i]) nodes[i] = '0;
      foreach (free_list[i]) begin
        free_list[i] = '0;
        free_node[i] = 0;
      end
      nodes[0] = '{x: 16'd0, y: 16'd0, w: atlas_w, h: atlas_h};
      node_cnt = 1;
      free_list[0] = nodes[0];
      free_cnt = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == REG_ATLAS_W) atlas_w = val;
      else atlas_h = val;
      clear_store();
    endfunction

    function int unsigned area_key(rect_t r);
      return int'(r.w) + int'(r.h);
    endfunction

    function void resort();
      rect_t r;
      int    n;
      int    j;
      for (int i = 1; i < free_cnt; i++) begin
        r = free_list[i];
        n = free_node[i];
        j = i;
        while (j > 0 && area_key(free_list[j-1]) > area_key(r)) begin
          free_list[j] = free_list[j-1];
          free_node[j] = free_node[j-1];
          j--;
        end
        free_list[j] = r;
        free_node[j] = n;
      end
    endfunction

    function void note_item(logic func, logic [15:0] rw, logic [15:0] rh, logic [7:0] key);
      alloc_res_t r;
      rect_t      src;
      int         hit;
      r = '0;
      hit = -1;
      if (func) begin
        n_get++;
        r.idx = key;
        if (int'(key) < node_cnt) begin
          r.ok = 1'b1;
          r.rect = nodes[key];
        end
      end else if (node_cnt + 3 <= MAX_NODES && free_cnt + 1 <= MAX_FREE) begin
        for (int i = 0; i < free_cnt; i++) begin
          if (free_list[i].w >= rw && free_list[i].h >= rh) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          src = free_list[hit];
          nodes[node_cnt]   = '{x: src.x, y: src.y, w: rw, h: rh};
          nodes[node_cnt+1] = '{x: src.x + rw, y: src.y, w: src.w - rw, h: rh};
          nodes[node_cnt+2] = '{x: src.x, y: src.y + rh, w: src.w, h: src.h - rh};
          free_list[hit] = nodes[node_cnt+1];
          free_node[hit] = node_cnt + 1;
          free_list[free_cnt] = nodes[node_cnt+2];
          free_node[free_cnt] = node_cnt + 2;
          free_cnt++;
          r.ok = 1'b1;
          r.idx = node_cnt[7:0];
          r.rect = nodes[node_cnt];
          node_cnt += 3;
          resort();
        end
      end
      if (!func) begin
        if (r.ok) n_ins_ok++;
        else n_ins_fail++;
      end
      awaited.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(alloc_res_t got);
      alloc_res_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing outstanding", $time);
        errors++;
      end else begin
        want = awaited.pop_front();
        n_checked++;
        if (got.ok !== want.ok) report("ok", got.ok, want.ok);
        if (got.idx !== want.idx) report("node_index", got.idx, want.idx);
        if (got.rect.x !== want.rect.x) report("rect_x", got.rect.x, want.rect.x);
        if (got.rect.y !== want.rect.y) report("rect_y", got.rect.y, want.rect.y);
        if (got.rect.w !== want.rect.w) report("rect_w", got.rect.w, want.rect.w);
        if (got.rect.h !== want.rect.h) report("rect_h", got.rect.h, want.rect.h);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  int src_idle_pct;
  int snk_stall_pct;
  int quiet_cycles;
  int n_cfg;

  gra_in_if  in_ch();
  gra_out_if out_ch();

  atlas_scoreboard sb;

  guillotine_rect_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.func, in_ch.req_width, in_ch.req_height, in_ch.node_key);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{ok: out_ch.ok, idx: out_ch.node_index,
                        rect: '{x: out_ch.rect_x, y: out_ch.rect_y,
                                w: out_ch.rect_w, h: out_ch.rect_h}});
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 40000) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.awaited.size());
      $display("** guillotine_rect_allocator: FAILED **");
      $finish;
    end
  end

  task automatic send_item(logic func, logic [15:0] rw, logic [15:0] rh, logic [7:0] key);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.req_width  <= rw;
    in_ch.req_height <= rh;
    in_ch.node_key   <= key;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_atlas(logic [15:0] aw, logic [15:0] ah);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ATLAS_W;
    cfg_wdata <= aw;
    @(posedge clk);
    sb.write_reg(REG_ATLAS_W, aw);
    cfg_index <= REG_ATLAS_H;
    cfg_wdata <= ah;
    @(posedge clk);
    sb.write_reg(REG_ATLAS_H, ah);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_cfg++;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned aw;
    int unsigned ah;
    pick = $urandom_range(0, 99);
    aw = sb.atlas_w;
    ah = sb.atlas_h;
    if (pick < 15)
      send_item(1'b1, 16'($urandom), 16'($urandom),
                8'($urandom_range(0, sb.node_cnt)));
    else if (pick < 20)
      send_item(1'b1, 16'($urandom), 16'($urandom), 8'($urandom));
    else if (pick < 28)
      send_item(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
    else
      send_item(1'b0, 16'($urandom_range(0, aw / 5 + 1)),
                16'($urandom_range(0, ah / 5 + 1)), 8'($urandom));
  endtask

  initial begin
    int idle_tab[4][2];
    logic [15:0] aw;
    logic [15:0] ah;
    idle_tab = '{'{0, 0}, '{65, 0}, '{0, 65}, '{20, 20}};
    sb = new();
    n_cfg = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.req_width = '0;
    in_ch.req_height = '0;
    in_ch.node_key = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(1'b0, 16'd0, 16'd0, 8'd0);
    send_item(1'b0, 16'd1024, 16'd1024, 8'd0);
    send_item(1'b0, 16'd1, 16'd1, 8'd0);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(1'b1, 16'd0, 16'd0, 8'd0);
    send_item(1'b1, 16'd0, 16'd0, 8'd4);
    send_item(1'b1, 16'd0, 16'd0, 8'd6);
    send_item(1'b1, 16'd0, 16'd0, 8'd7);
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(1'b0, 16'd0, 16'd0, 8'd0);
    write_atlas(16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'hFFFF, 16'd1, 8'd0);
    send_item(1'b0, 16'd1, 16'hFFFE, 8'd0);
    send_item(1'b0, 16'hAAAA, 16'h5555, 8'd0);
    send_item(1'b1, 16'd0, 16'd0, 8'd3);
    send_item(1'b1, 16'd0, 16'd0, 8'd8);
    write_atlas(16'd0, 16'd0);
    send_item(1'b0, 16'd1, 16'd0, 8'd0);
    send_item(1'b0, 16'd0, 16'd0, 8'd0);
    send_item(1'b1, 16'd0, 16'd0, 8'd0);
    write_atlas(16'd1, 16'hFFFF);
    send_item(1'b0, 16'd1, 16'h8000, 8'd0);
    send_item(1'b0, 16'd1, 16'h8000, 8'd0);

    for (int ph = 0; ph < 8; ph++) begin
      src_idle_pct  = idle_tab[ph % 4][0];
      snk_stall_pct = idle_tab[ph % 4][1];
      case (ph)
        0: begin aw = 16'd1024; ah = 16'd1024; end
        1: begin aw = 16'hFFFF; ah = 16'hFFFF; end
        2: begin aw = 16'd0;    ah = 16'd300;  end
        default: begin aw = 16'($urandom); ah = 16'($urandom_range(1, 4096)); end
      endcase
      write_atlas(aw, ah);
      for (int k = 0; k < 100; k++) begin
        if (ph == 1 && k == 50) drain();
        random_item();
      end
    end

    drain();
    $display("Run covered %0d accepted inserts, %0d failed inserts, %0d reads back,",
             sb.n_ins_ok, sb.n_ins_fail, sb.n_get);
    $display("%0d results checked across %0d atlas settings with mixed idle patterns.",
             sb.n_checked, n_cfg + 1);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("** guillotine_rect_allocator: PASSED **");
    end else begin
      $display("** guillotine_rect_allocator: FAILED **");
    end
    $finish;
  end

endmodule
